>>> sv/cc3_pkg.sv
// Shared constants, types and control structs of the 3x3 convolution stream unit.
package cc3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int KS        = 3;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FILL_W    = COL_W + 1;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 12;
  localparam int KROW_W    = 24;
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 8;
  localparam int PROD_W    = 17;
  localparam int CSUM_W    = 18;
  localparam int SUM_W     = 20;
  localparam int FRAC_W    = 4;
  localparam int MAG_W     = 23;
  localparam int OUT_W     = 20;
  localparam int ODATA_W   = 24;
  localparam int CIDX_W    = 3;
  localparam int MUL_W     = 2 * MAG_W;
  localparam int DIV_BY    = 9;
  localparam int DIV_SHIFT = 26;
  localparam int DIV_MUL   = (1 << DIV_SHIFT) / DIV_BY;

  localparam logic [KROW_W-1:0] KROW_RESET   = 24'h010101;
  localparam logic [WID_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HGT_W-1:0]  HEIGHT_RESET = 12'd1024;

  typedef enum logic [CIDX_W-1:0] {
    CFG_KERN_TOP = 3'd0,
    CFG_KERN_MID = 3'd1,
    CFG_KERN_BOT = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    PH_MAIN,
    PH_FLUSH
  } s1_phase_t;

  typedef logic [PIX_W-1:0]                pix_t;
  typedef logic [KS-1:0][PIX_W-1:0]        pix_col_t;
  typedef logic [KS-1:0][COEF_W-1:0]       coef_col_t;
  typedef logic signed [CSUM_W-1:0]        csum_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic load_mul;
    logic load_out;
  } div_ctrl_t;

endpackage

>>> sv/conv3x3_zero_pad_stream_unit.sv
// Top level of the 3x3 zero-padded convolution stream unit.
// An accepted pixel passes the window stage, cell pixel and sum, magnitude and both
// divider registers. Throughput: one pixel per cycle unless the output stalls; a row's
// last column gives two results through the window cells, so input waits at row ends
// once rows are filled. Reset clears control state and loads the register defaults;
// the line stores are not swept, a fill count makes never-written entries read as zero.
module conv3x3_zero_pad_stream_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cc3_pkg::PIX_W-1:0]        s_tdata,  // [7:0] pixel
  input  logic                             s_tuser,  // [0] action
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cc3_pkg::ODATA_W-1:0]      m_tdata,  // [19:0] filtered, [23:20] zero
  output logic                             m_tlast,  // last_of_frame
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cc3_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [cc3_pkg::KROW_W-1:0]       cfg_data
);

  localparam int KS = cc3_pkg::KS;

  // Configuration registers.
  logic [cc3_pkg::KROW_W-1:0] kern_top;
  logic [cc3_pkg::KROW_W-1:0] kern_mid;
  logic [cc3_pkg::KROW_W-1:0] kern_bot;
  logic [cc3_pkg::WID_W-1:0]  frame_width;
  logic [cc3_pkg::HGT_W-1:0]  frame_height;

  // Raster position and line store fill count.
  logic [cc3_pkg::COL_W-1:0]  column_count;
  logic [cc3_pkg::HGT_W-1:0]  row_count;
  logic [cc3_pkg::FILL_W-1:0] fill;
  logic [cc3_pkg::FILL_W-1:0] fill_next;

  logic [cc3_pkg::FILL_W-1:0] w_eff;
  logic [cc3_pkg::COL_W-1:0]  wm1;
  logic [cc3_pkg::HGT_W-1:0]  h_eff;
  logic [cc3_pkg::COL_W-1:0]  col0;
  logic                       draining;
  logic                       last_col;
  logic                       acc;
  logic                       item_acc;

  // Window stage.
  cc3_pkg::s1_phase_t         phase;
  cc3_pkg::s1_phase_t         phase_next;
  logic                       v1;
  cc3_pkg::pix_t              p1;
  logic [cc3_pkg::COL_W-1:0]  col1;
  logic                       zero1;
  logic                       fwd1;
  cc3_pkg::pix_t              fa1;
  cc3_pkg::pix_t              fb1;
  logic                       e1_1;
  logic                       e2_1;
  logic                       clr1;
  logic                       last1;
  logic                       fire1;
  logic                       s1_done;
  logic                       wr_en;
  logic                       s1_emit;
  logic                       s1_last;
  logic                       zero_in;
  cc3_pkg::pix_t              rd_a;
  cc3_pkg::pix_t              rd_b;
  cc3_pkg::pix_t              ra;
  cc3_pkg::pix_t              rb;

  // Later stages.
  logic                       v2, v3, v4, v5;
  logic                       last2, last3, last4, last5;
  logic                       rdy2, rdy3, rdy4, rdy5, rdy_o;
  logic                       fire2, fire3, fire4, fire5;
  logic signed [cc3_pkg::SUM_W-1:0] total;
  logic [cc3_pkg::SUM_W-1:0]  mag;
  logic [cc3_pkg::MAG_W-1:0]  a4;
  logic                       neg4;
  logic signed [cc3_pkg::OUT_W-1:0] quot;
  logic                       out_last;

  cc3_pkg::cell_ctrl_t        cell_ctrl;
  cc3_pkg::div_ctrl_t         div_ctrl;
  cc3_pkg::pix_col_t          cell_pix [KS];
  cc3_pkg::pix_col_t          cell_in  [KS];
  cc3_pkg::coef_col_t         cell_coef [KS];
  cc3_pkg::csum_t             csum [KS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kern_top     <= cc3_pkg::KROW_RESET;
      kern_mid     <= cc3_pkg::KROW_RESET;
      kern_bot     <= cc3_pkg::KROW_RESET;
      frame_width  <= cc3_pkg::WIDTH_RESET;
      frame_height <= cc3_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cc3_pkg::CFG_KERN_TOP: kern_top     <= cfg_data;
        cc3_pkg::CFG_KERN_MID: kern_mid     <= cfg_data;
        cc3_pkg::CFG_KERN_BOT: kern_bot     <= cfg_data;
        cc3_pkg::CFG_WIDTH:    frame_width  <= cfg_data[cc3_pkg::WID_W-1:0];
        cc3_pkg::CFG_HEIGHT:   frame_height <= cfg_data[cc3_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = cc3_pkg::FILL_W'(1);
    end else if (int'(frame_width) > cc3_pkg::MAX_WIDTH) begin
      w_eff = cc3_pkg::FILL_W'(cc3_pkg::MAX_WIDTH);
    end else begin
      w_eff = cc3_pkg::FILL_W'(frame_width);
    end
    wm1      = cc3_pkg::COL_W'(w_eff - cc3_pkg::FILL_W'(1));
    h_eff    = (frame_height == '0) ? cc3_pkg::HGT_W'(1) : frame_height;
    draining = row_count >= h_eff;
    col0     = ({1'b0, column_count} < w_eff) ? column_count : wm1;
    last_col = col0 == wm1;
  end

  assign acc      = s_tvalid && s_tready;
  assign item_acc = acc && (s_tuser == draining);

  // Stage handshakes: a slot is free when empty or when its beat moves on.
  assign rdy_o = !m_tvalid || m_tready;
  assign fire5 = v5 && rdy_o;
  assign rdy5  = !v5 || rdy_o;
  assign fire4 = v4 && rdy5;
  assign rdy4  = !v4 || rdy5;
  assign fire3 = v3 && rdy4;
  assign rdy3  = !v3 || rdy4;
  assign fire2 = v2 && rdy3;
  assign rdy2  = !v2 || rdy3;
  assign fire1 = v1 && rdy2;

  always_comb begin
    phase_next = phase;
    case (phase)
      cc3_pkg::PH_MAIN: begin
        if (fire1 && e2_1) begin
          phase_next = cc3_pkg::PH_FLUSH;
        end
      end
      cc3_pkg::PH_FLUSH: begin
        if (fire1) begin
          phase_next = cc3_pkg::PH_MAIN;
        end
      end
      default: phase_next = cc3_pkg::PH_MAIN;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    s1_emit = 1'b0;
    s1_last = 1'b0;
    zero_in = 1'b0;
    s1_done = 1'b0;
    case (phase)
      cc3_pkg::PH_MAIN: begin
        wr_en   = fire1;
        s1_emit = e1_1;
        zero_in = clr1;
        s1_done = fire1 && !e2_1;
      end
      cc3_pkg::PH_FLUSH: begin
        s1_emit = 1'b1;
        s1_last = last1;
        s1_done = fire1;
      end
      default: ;
    endcase
  end

  assign s_tready = !v1 || s1_done;

  assign ra = zero1 ? '0 : (fwd1 ? fa1 : rd_a);
  assign rb = zero1 ? '0 : (fwd1 ? fb1 : rd_b);

  always_comb begin
    fill_next = fill;
    if (wr_en && ({1'b0, col1} >= fill)) begin
      fill_next = {1'b0, col1} + cc3_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      fill         <= '0;
      phase        <= cc3_pkg::PH_MAIN;
      v1           <= 1'b0;
    end else begin
      fill  <= fill_next;
      phase <= phase_next;
      if (item_acc) begin
        v1 <= 1'b1;
        if (last_col) begin
          column_count <= '0;
          row_count    <= draining ? '0 : row_count + cc3_pkg::HGT_W'(1);
        end else begin
          column_count <= col0 + cc3_pkg::COL_W'(1);
        end
      end else if (s1_done) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      p1    <= draining ? '0 : s_tdata;
      col1  <= col0;
      zero1 <= (row_count == '0) || ({1'b0, col0} >= fill_next);
      fwd1  <= wr_en && (col0 == col1);
      fa1   <= p1;
      fb1   <= ra;
      e1_1  <= (row_count != '0) && (col0 != '0);
      e2_1  <= (row_count != '0) && last_col;
      clr1  <= col0 == '0;
      last1 <= draining;
    end
  end

  cc3_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (item_acc),
    .rd_addr (col0),
    .wr_en   (wr_en),
    .wr_addr (col1),
    .wr_a    (p1),
    .wr_b    (ra),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  assign cell_ctrl.shift = fire1;
  assign cell_ctrl.load  = fire2;

  for (genvar k = 0; k < KS; k++) begin : g_cell
    assign cell_coef[k][0] = kern_top[k*cc3_pkg::COEF_W +: cc3_pkg::COEF_W];
    assign cell_coef[k][1] = kern_mid[k*cc3_pkg::COEF_W +: cc3_pkg::COEF_W];
    assign cell_coef[k][2] = kern_bot[k*cc3_pkg::COEF_W +: cc3_pkg::COEF_W];
    if (k == KS - 1) begin : g_right
      assign cell_in[k] = (phase == cc3_pkg::PH_FLUSH) ? '0 : {p1, ra, rb};
    end else begin : g_inner
      assign cell_in[k] = zero_in ? '0 : cell_pix[k+1];
    end
    cc3_cell u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl),
      .coef (cell_coef[k]),
      .din  (cell_in[k]),
      .pix  (cell_pix[k]),
      .csum (csum[k])
    );
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < KS; k++) begin
      total = total + cc3_pkg::SUM_W'(csum[k]);
    end
    mag = total[cc3_pkg::SUM_W-1] ? cc3_pkg::SUM_W'(-total) : cc3_pkg::SUM_W'(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy2) v2 <= fire1 && s1_emit;
      if (rdy3) v3 <= fire2;
      if (rdy4) v4 <= fire3;
      if (rdy5) v5 <= fire4;
      if (rdy_o) m_tvalid <= fire5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) last2 <= s1_last;
    if (rdy3) last3 <= last2;
    if (fire3) begin
      last4 <= last3;
      a4    <= {mag[cc3_pkg::MAG_W-cc3_pkg::FRAC_W-1:0], {cc3_pkg::FRAC_W{1'b0}}};
      neg4  <= total[cc3_pkg::SUM_W-1];
    end
    if (fire4) last5 <= last4;
    if (fire5) out_last <= last5;
  end

  assign div_ctrl.load_mul = fire4;
  assign div_ctrl.load_out = fire5;

  cc3_div9 u_div9 (
    .clk  (clk),
    .ctrl (div_ctrl),
    .mag  (a4),
    .neg  (neg4),
    .quot (quot)
  );

  assign m_tdata = {{(cc3_pkg::ODATA_W - cc3_pkg::OUT_W){1'b0}}, quot};
  assign m_tlast = out_last;

  a_flush_after_row_end: assert property (@(posedge clk) disable iff (rst)
    (v1 && phase == cc3_pkg::PH_FLUSH) |-> e2_1)
    else $error("flush phase without a row-end beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= cc3_pkg::MAX_WIDTH)
    else $error("line store fill count past depth");

  a_row_holds: assert property (@(posedge clk) disable iff (rst)
    (item_acc && !last_col) |=> $stable(row_count))
    else $error("row count moved before the row end");

  a_flush_emits: assert property (@(posedge clk) disable iff (rst)
    (fire1 && phase == cc3_pkg::PH_FLUSH) |=> (v2 && last2 == $past(last1)))
    else $error("right column result lost");

endmodule

>>> sv/cc3_linebuf.sv
// Two line stores holding the previous row and the row before it, read-first.
module cc3_linebuf (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [cc3_pkg::COL_W-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [cc3_pkg::COL_W-1:0] wr_addr,
  input  cc3_pkg::pix_t            wr_a,
  input  cc3_pkg::pix_t            wr_b,
  output cc3_pkg::pix_t            rd_a,
  output cc3_pkg::pix_t            rd_b
);

  cc3_pkg::pix_t store_a [cc3_pkg::MAX_WIDTH];
  cc3_pkg::pix_t store_b [cc3_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= store_a[rd_addr];
      rd_b <= store_b[rd_addr];
    end
    if (wr_en) begin
      store_a[wr_addr] <= wr_a;
      store_b[wr_addr] <= wr_b;
    end
  end

endmodule

>>> sv/cc3_cell.sv
// One window column cell: three pixels, shifted from the right neighbor, and its weighted sum.
module cc3_cell (
  input  logic               clk,
  input  cc3_pkg::cell_ctrl_t ctrl,
  input  cc3_pkg::coef_col_t  coef,
  input  cc3_pkg::pix_col_t   din,
  output cc3_pkg::pix_col_t   pix,
  output cc3_pkg::csum_t      csum
);

  logic signed [cc3_pkg::PROD_W-1:0] prod [cc3_pkg::KS];
  cc3_pkg::csum_t                    csum_next;

  always_comb begin
    csum_next = '0;
    for (int r = 0; r < cc3_pkg::KS; r++) begin
      prod[r]   = $signed(coef[r]) * $signed({1'b0, pix[r]});
      csum_next = csum_next + cc3_pkg::CSUM_W'(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pix <= din;
    end
    if (ctrl.load) begin
      csum <= csum_next;
    end
  end

endmodule

>>> sv/cc3_div9.sv
// Divide-by-nine unit: reciprocal multiply, then a one-step remainder correction and sign.
module cc3_div9 (
  input  logic                          clk,
  input  cc3_pkg::div_ctrl_t             ctrl,
  input  logic [cc3_pkg::MAG_W-1:0]      mag,
  input  logic                          neg,
  output logic signed [cc3_pkg::OUT_W-1:0] quot
);

  logic [cc3_pkg::MUL_W-1:0]   prod;
  logic [cc3_pkg::MAG_W-1:0]   mag_m;
  logic                        neg_m;
  logic [cc3_pkg::OUT_W-1:0]   q0;
  logic [cc3_pkg::MAG_W:0]     q9;
  logic [cc3_pkg::MAG_W:0]     rem;
  logic [cc3_pkg::OUT_W-1:0]   qf;

  assign prod = cc3_pkg::MUL_W'(mag) * cc3_pkg::MUL_W'(cc3_pkg::DIV_MUL);

  always_comb begin
    q9  = {q0, 3'b000} + (cc3_pkg::MAG_W + 1)'(q0);
    rem = (cc3_pkg::MAG_W + 1)'(mag_m) - q9;
    qf  = q0 + ((rem >= (cc3_pkg::MAG_W + 1)'(cc3_pkg::DIV_BY)) ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mul) begin
      q0    <= prod[cc3_pkg::DIV_SHIFT +: cc3_pkg::OUT_W];
      mag_m <= mag;
      neg_m <= neg;
    end
    if (ctrl.load_out) begin
      quot <= neg_m ? $signed(-qf) : $signed(qf);
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the 3x3 zero-padded convolution stream unit.
package conv_check_pkg;
  import cc3_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] filtered;
    logic             last_of_frame;
  } conv_out_t;

  class conv_scoreboard;
    logic [KROW_W-1:0] kern_row [KS];
    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [PIX_W-1:0]  prev_row [MAX_WIDTH];
    logic [PIX_W-1:0]  older_row [MAX_WIDTH];
    logic [PIX_W-1:0]  win [KS][KS];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    bit                in_drain;
    conv_out_t         pending_sums [$];
    int                errors;

    function new();
      for (int r = 0; r < KS; r++) kern_row[r] = KROW_RESET;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        prev_row[i] = '0;
        older_row[i] = '0;
      end
      clear_window();
      col_cnt = 0;
      row_cnt = 0;
      in_drain = 0;
      errors = 0;
    endfunction

    function void clear_window();
      for (int r = 0; r < KS; r++)
        for (int c = 0; c < KS; c++) win[r][c] = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [KROW_W-1:0] val);
      case (idx)
        CFG_KERN_TOP, CFG_KERN_MID, CFG_KERN_BOT: kern_row[idx] = val;
        CFG_WIDTH: width_reg = val[WID_W-1:0];
        CFG_HEIGHT: height_reg = val[HGT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    function void shift_column(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                               logic [PIX_W-1:0] bot);
      for (int r = 0; r < KS; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
    endfunction

    function void push_sum(bit last);
      longint acc;
      int coef;
      conv_out_t e;
      acc = 0;
      for (int r = 0; r < KS; r++)
        for (int c = 0; c < KS; c++) begin
          coef = $signed(kern_row[r][8*c +: 8]);
          acc += longint'(coef) * longint'(int'(win[r][c]));
        end
      acc = (acc * 16) / 9;
      e.filtered = acc[OUT_W-1:0];
      e.last_of_frame = last;
      pending_sums.push_back(e);
    endfunction

    // Returns 1 when the beat takes part in the image, 0 when the block ignores it.
    function bit accept_beat(bit drain_tick, logic [PIX_W-1:0] pix);
      int unsigned w, h, col;
      logic [PIX_W-1:0] p, ra, rb;
      w = eff_width();
      h = eff_height();
      in_drain = (row_cnt >= h);
      if (drain_tick != in_drain) return 0;
      p = in_drain ? '0 : pix;
      col = (col_cnt < w) ? col_cnt : w - 1;
      ra = (row_cnt == 0) ? '0 : prev_row[col];
      rb = (row_cnt == 0) ? '0 : older_row[col];
      older_row[col] = ra;
      prev_row[col] = p;
      if (col == 0) clear_window();
      shift_column(rb, ra, p);
      if (row_cnt >= 1) begin
        if (col >= 1) push_sum(0);
        if (col == w - 1) begin
          shift_column('0, '0, '0);
          push_sum(in_drain);
        end
      end
      if (col == w - 1) begin
        col_cnt = 0;
        if (in_drain) begin
          row_cnt = 0;
          in_drain = 0;
        end else begin
          row_cnt = (row_cnt + 1) & 12'hFFF;
          in_drain = (row_cnt >= h);
        end
      end else begin
        col_cnt = col + 1;
      end
      return 1;
    endfunction

    function void compare_output(logic [ODATA_W-1:0] tdata, logic tlast);
      conv_out_t e;
      if (pending_sums.size() == 0) begin
        $error("unexpected output beat: filtered %0d, last_of_frame %0b",
               $signed(tdata[OUT_W-1:0]), tlast);
        errors++;
        return;
      end
      e = pending_sums.pop_front();
      if (tdata[OUT_W-1:0] !== e.filtered) begin
        $error("filtered: expected %0d, actual %0d", $signed(e.filtered),
               $signed(tdata[OUT_W-1:0]));
        errors++;
      end
      if (tdata[ODATA_W-1:OUT_W] !== '0) begin
        $error("tdata pad: expected 0, actual %0h", tdata[ODATA_W-1:OUT_W]);
        errors++;
      end
      if (tlast !== e.last_of_frame) begin
        $error("last_of_frame: expected %0b, actual %0b", e.last_of_frame, tlast);
        errors++;
      end
    endfunction
  endclass
endpackage

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cc3_pkg::*;
  import conv_check_pkg::*;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [PIX_W-1:0]   s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [ODATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_idx_t           cfg_index;
  logic [KROW_W-1:0]  cfg_data;

  conv_scoreboard sb;
  bit sender_calm;
  bit hold_req;
  bit hold_done;
  int pixels_taken;

  conv3x3_zero_pad_stream_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.compare_output(m_tdata, m_tlast);
  end

  // Output side: random ready pattern, plus one long hold-off on request.
  initial begin
    int left;
    bit cur;
    m_tready = 0;
    left = 0;
    cur = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready = 0;
        repeat (2000) @(negedge clk);
        hold_done = 1;
        m_tready = 1;
      end else if (left > 0) begin
        left--;
        m_tready = cur;
      end else begin
        case ($urandom_range(0, 9))
          0: begin cur = 1; left = $urandom_range(100, 300); end
          1, 2, 3, 4: begin cur = 1; left = $urandom_range(1, 8); end
          5, 6, 7: begin cur = 0; left = $urandom_range(1, 3); end
          default: begin cur = 0; left = $urandom_range(10, 60); end
        endcase
        m_tready = cur;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int mode);
    case (mode)
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel_row();
    logic [KROW_W-1:0] v;
    logic [7:0] picks [5];
    picks = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01};
    if ($urandom_range(0, 1)) return $urandom;
    for (int c = 0; c < KS; c++) v[8*c +: 8] = picks[$urandom_range(0, 4)];
    return v;
  endfunction

  task automatic send_beat(bit drain_tick, logic [PIX_W-1:0] pix);
    int g;
    g = sender_calm ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid = 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tuser = drain_tick;
    s_tdata = pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.accept_beat(drain_tick, pix)) pixels_taken++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [KROW_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // The block may still hold beats that give no output, so let it settle first.
  task automatic configure(logic [KROW_W-1:0] top, logic [KROW_W-1:0] mid,
                           logic [KROW_W-1:0] bot, logic [KROW_W-1:0] w,
                           logic [KROW_W-1:0] h);
    wait_all_results();
    repeat (12) @(posedge clk);
    write_reg(CFG_KERN_TOP, top);
    write_reg(CFG_KERN_MID, mid);
    write_reg(CFG_KERN_BOT, bot);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic run_frame(int noise_pct, int pix_mode, int pause_at);
    int unsigned w, h;
    int n;
    w = sb.eff_width();
    h = sb.eff_height();
    n = 0;
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++) begin
        if (n == pause_at) wait_all_results();
        if ($urandom_range(0, 99) < noise_pct) send_beat(1, $urandom);
        send_beat(0, pick_pixel(pix_mode));
        n++;
      end
    for (int unsigned c = 0; c < w; c++) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(0, $urandom);
      send_beat(1, $urandom);
    end
  endtask

  initial begin
    logic [KROW_W-1:0] w, h;
    int frame_no;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = 0;
    cfg_valid = 0;
    cfg_index = CFG_KERN_TOP;
    cfg_data = '0;
    sender_calm = 0;
    hold_req = 0;
    hold_done = 0;
    pixels_taken = 0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: largest and smallest sums, ignored beats, single-pixel frame.
    configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 3, 3);
    run_frame(20, 2, -1);
    configure(24'h808080, 24'h808080, 24'h808080, 3, 3);
    run_frame(0, 2, -1);
    configure(24'h00FF01, 24'h7F8000, 24'h01807F, 1, 1);
    run_frame(0, 0, -1);
    run_frame(0, 1, -1);

    // Register extremes.
    configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 1024, 1);
    run_frame(2, 0, -1);
    configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 1, 4095);
    run_frame(2, 0, -1);

    pixels_taken = 0;
    frame_no = 0;
    while (pixels_taken < 1050) begin
      case ($urandom_range(0, 29))
        0: begin w = 0; h = $urandom_range(1, 6); end
        1: begin w = $urandom_range(1, 12); h = 0; end
        2: begin w = 2047; h = 1; end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 10); end
      endcase
      if (frame_no == 2) begin
        w = 16;
        h = 12;
      end
      configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), w, h);
      sender_calm = (frame_no == 2) || ($urandom_range(0, 3) == 0);
      if (frame_no == 2) hold_req = 1;
      run_frame($urandom_range(0, 1) ? 5 : 0, $urandom_range(0, 4) == 0 ? 1 : 0,
                frame_no == 4 ? sb.eff_width() * sb.eff_height() / 2 : -1);
      frame_no++;
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/cc3_pkg.sv
sv/cc3_linebuf.sv
sv/cc3_cell.sv
sv/cc3_div9.sv
sv/conv3x3_zero_pad_stream_unit.sv
dv/testbench.sv
